>>> hw/rtl/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg
// Shared operation codes, pipeline stage type and the divide step function
// for the multiply/divide unit.
// ----------------------------------------------------------------------------
package mdu_pkg;

  // Operation selector codes.
  localparam logic [1:0] OP_MULT  = 2'd0;
  localparam logic [1:0] OP_MULTU = 2'd1;
  localparam logic [1:0] OP_DIV   = 2'd2;
  localparam logic [1:0] OP_DIVU  = 2'd3;

  localparam int unsigned WordW     = 32;
  localparam logic [31:0] SignWord  = 32'h8000_0000;
  localparam logic [31:0] OnesWord  = 32'hFFFF_FFFF;

  // One pipeline stage of payload. For a multiply, acc holds the operand
  // magnitude and later the product; for a divide it is the partial
  // remainder over the remaining dividend bits and the quotient bits so far.
  typedef struct packed {
    logic [1:0]  func;
    logic        neg_prod;
    logic        neg_lo;
    logic        neg_hi;
    logic        zero_sdiv;
    logic        fault;
    logic [31:0] divisor;
    logic [63:0] acc;
  } stage_t;

  // One restoring division step: shift one dividend bit into the remainder,
  // subtract the divisor if it fits and shift the quotient bit in.
  function automatic logic [63:0] div_step(input logic [63:0] acc,
                                           input logic [31:0] divisor);
    logic [32:0] trial;
    logic [63:0] res;
    trial = acc[63:31] - {1'b0, divisor};
    if (!trial[32]) begin
      res = {trial[31:0], acc[30:0], 1'b1};
    end else begin
      res = {acc[62:0], 1'b0};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/mips_mult_div_unit.sv
// ----------------------------------------------------------------------------
// mips_mult_div_unit
// Pipelined MIPS-style multiply/divide unit giving the HI and LO words.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries func, operand_a and
// operand_b; the output channel (out_valid/out_ready) carries hi_word,
// lo_word and fault. Every beat in gives exactly one beat out, in order.
// Signed and unsigned multiply return the 64-bit product; divides return the
// quotient in LO and the remainder in HI. Unsigned divide by zero and the
// signed overflow divide raise fault with the R3000 values; signed divide by
// zero returns zeros.
// A beat passes through one entry stage that takes operand magnitudes and
// loads on the input beat, 32 stages of one restoring divide step each (the
// multiply is done in the first of these and then carried along), and one
// sign fix-up stage that also serves as the output register.
// Throughput is one beat per cycle. Each stage moves when its successor is
// empty or moving, so a stalled receiver only holds the full stages and
// bubbles still fill; input is refused once every stage is full and stalled.
// Reset clears all stage valid bits; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module mips_mult_div_unit
  import mdu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hi_word,
  output logic [31:0] lo_word,
  output logic        fault
);

  localparam int unsigned Steps  = WordW;
  localparam int unsigned Stages = Steps + 2;
  localparam int unsigned Last   = Stages - 1;

  logic   vld [Stages];
  logic   rdy [Stages];
  stage_t stg [Last];
  stage_t entry_next;
  logic [1:0] out_func;

  // Ready ripples back: a stage can load when it is empty or draining.
  always_comb begin
    rdy[Last] = !vld[Last] || out_ready;
    for (int i = Last - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[Last];

  // Entry stage: decode the operation and take operand magnitudes.
  always_comb begin
    logic is_signed, a_neg, b_neg;
    is_signed = !func[0];
    a_neg     = is_signed && operand_a[31];
    b_neg     = is_signed && operand_b[31];
    entry_next.func      = func;
    entry_next.neg_prod  = a_neg ^ b_neg;
    entry_next.neg_lo    = a_neg ^ b_neg;
    entry_next.neg_hi    = a_neg;
    entry_next.zero_sdiv = (func == OP_DIV) && (operand_b == '0);
    entry_next.fault     = ((func == OP_DIVU) && (operand_b == '0)) ||
                           ((func == OP_DIV) && (operand_a == SignWord) &&
                            (operand_b == OnesWord));
    entry_next.divisor   = b_neg ? (~operand_b + 32'd1) : operand_b;
    entry_next.acc       = {32'd0, (a_neg ? (~operand_a + 32'd1) : operand_a)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
    if (rdy[0] && in_valid) begin
      stg[0] <= entry_next;
    end
  end

  // Divide steps; the first step stage also forms the multiply product.
  for (genvar k = 1; k <= Steps; k++) begin : g_step
    stage_t step_next;

    always_comb begin
      step_next = stg[k - 1];
      if (stg[k - 1].func[1]) begin
        step_next.acc = div_step(stg[k - 1].acc, stg[k - 1].divisor);
      end else if (k == 1) begin
        step_next.acc = {32'd0, stg[k - 1].acc[31:0]} * {32'd0, stg[k - 1].divisor};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k - 1];
      end
      if (rdy[k] && vld[k - 1]) begin
        stg[k] <= step_next;
      end
    end
  end

  // Sign fix-up and output register.
  always_ff @(posedge clk) begin
    logic [63:0] prod;
    prod = stg[Last - 1].neg_prod ? (~stg[Last - 1].acc + 64'd1) : stg[Last - 1].acc;
    if (rst) begin
      vld[Last] <= 1'b0;
    end else if (rdy[Last]) begin
      vld[Last] <= vld[Last - 1];
    end
    if (rdy[Last] && vld[Last - 1]) begin
      out_func <= stg[Last - 1].func;
      fault    <= stg[Last - 1].fault;
      if (!stg[Last - 1].func[1]) begin
        hi_word <= prod[63:32];
        lo_word <= prod[31:0];
      end else if (stg[Last - 1].zero_sdiv) begin
        hi_word <= '0;
        lo_word <= '0;
      end else begin
        hi_word <= stg[Last - 1].neg_hi ? (~stg[Last - 1].acc[63:32] + 32'd1)
                                        : stg[Last - 1].acc[63:32];
        lo_word <= stg[Last - 1].neg_lo ? (~stg[Last - 1].acc[31:0] + 32'd1)
                                        : stg[Last - 1].acc[31:0];
      end
    end
  end

  // A fault only ever comes from a divide.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> out_func[1])
    else $error("fault raised on a multiply result");

  // Input is refused only when the whole pipeline is full and stalled.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> vld[0] && vld[Last] && !out_ready)
    else $error("input refused while a stage could move");

  // Nothing leaves the block right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A faulting signed divide is the overflow case and gives the R3000 words.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_func == OP_DIV && fault |-> hi_word == '0 && lo_word == SignWord)
    else $error("signed overflow divide gave wrong words");

endmodule
